// File: hw/rtl/msi_pkg.sv
// ----------------------------------------------------------------------------
// msi_pkg
// Shared types and constants of the motion safety interlock: command codes,
// register indexes, configuration bundle and queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package msi_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] CMD_STOP  = 3'd0;
  localparam logic [2:0] CMD_ACCEL = 3'd1;
  localparam logic [2:0] CMD_SCAN  = 3'd2;
  localparam logic [2:0] CMD_VEL   = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  localparam logic [2:0] CFG_TIMEOUT = 3'd0;
  localparam logic [2:0] CFG_ROLL    = 3'd1;
  localparam logic [2:0] CFG_PITCH   = 3'd2;
  localparam logic [2:0] CFG_PROX    = 3'd3;
  localparam logic [2:0] CFG_ARC     = 3'd4;
  localparam logic [2:0] CFG_RMIN    = 3'd5;
  localparam logic [2:0] CFG_RMAX    = 3'd6;

  localparam logic [15:0] RST_TIMEOUT = 16'd40;
  localparam logic [15:0] RST_ROLL    = 16'd1910;
  localparam logic [15:0] RST_PITCH   = 16'd1491;
  localparam logic [15:0] RST_PROX    = 16'd300;
  localparam logic [13:0] RST_ARC     = 14'd2145;
  localparam logic [15:0] RST_RMIN    = 16'd0;
  localparam logic [15:0] RST_RMAX    = 16'd12000;

  localparam logic KIND_CMD    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    OP_STOP  = 3'd0,
    OP_ACCEL = 3'd1,
    OP_SCAN  = 3'd2,
    OP_VEL   = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  typedef struct packed {
    logic [15:0] timeout;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] prox;
    logic [13:0] arc;
    logic [15:0] rmin;
    logic [15:0] rmax;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic             stop_active;
    logic             scan_last;
    logic [5:0][31:0] vals;
  } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/msi_front.sv
// ----------------------------------------------------------------------------
// msi_front
// Input side: takes stream transactions, decodes the command selector,
// drops unknown commands and pushes classified entries into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module msi_front (
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [199:0]    s_axis_tdata,
  input  wire logic [2:0]      s_axis_tuser,
  input  wire logic            s_axis_tlast,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output msi_pkg::entry_t      q_entry_o
);

  logic known;

  always_comb begin
    known          = 1'b1;
    q_entry_o.op   = msi_pkg::OP_STOP;
    case (s_axis_tuser)
      msi_pkg::CMD_STOP:  q_entry_o.op = msi_pkg::OP_STOP;
      msi_pkg::CMD_ACCEL: q_entry_o.op = msi_pkg::OP_ACCEL;
      msi_pkg::CMD_SCAN:  q_entry_o.op = msi_pkg::OP_SCAN;
      msi_pkg::CMD_VEL:   q_entry_o.op = msi_pkg::OP_VEL;
      msi_pkg::CMD_TICK:  q_entry_o.op = msi_pkg::OP_TICK;
      default:            known        = 1'b0;
    endcase
    q_entry_o.stop_active = s_axis_tdata[0];
    q_entry_o.scan_last   = s_axis_tlast;
    q_entry_o.vals        = s_axis_tdata[192:1];
  end

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i && known;

endmodule

`default_nettype wire

// File: hw/rtl/msi_queue.sv
// ----------------------------------------------------------------------------
// msi_queue
// Short register queue between the front and the back (depth set by Depth, 2 by default).
// ----------------------------------------------------------------------------
`default_nettype none

module msi_queue #(
  parameter int unsigned Depth = msi_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire msi_pkg::entry_t entry_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output msi_pkg::entry_t      entry_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  msi_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/msi_back.sv
// ----------------------------------------------------------------------------
// msi_back
// Execution side: holds the fault state, runs the tilt check on one shared
// multiplier over nine steps, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msi_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire msi_pkg::cfg_t    cfg_i,
  input  wire logic             q_valid_i,
  input  wire msi_pkg::entry_t  q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  out_kind_o,
  output logic [5:0][31:0]      out_vals_o,
  output logic [4:0]            out_status_o,
  output logic                  out_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_TILT   = 3'b010,
    ST_SECOND = 3'b100
  } state_e;

  localparam logic [3:0] StepLast = 4'd8;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  state_e st_q, st_d;
  logic [3:0] step_q;

  logic stop_q, wd_q, tilt_q, prox_q, open_q;
  logic [15:0] ticks_q, min_q;

  logic signed [31:0] ax_q, ay_q, az_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q, acc_q, s_q, sq_q, lo_q;
  logic [31:0] pp_q;
  logic [47:0] rp_q;
  logic [95:0] rhs_q;
  logic [31:0] ux, uy, uz;

  logic out_valid_q, out_kind_q, out_last_q;
  logic [5:0][31:0] out_vals_q;
  logic [4:0] out_status_q;

  logic slot_free, pop;
  logic [15:0] ticks_d, scan_b16, base, new_min;
  logic wd_tick, safe_tick, scan_ok, roll_f, pitch_f, safe_now;

  assign ux = mag32(ax_q);
  assign uy = mag32(ay_q);
  assign uz = mag32(az_q);

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop       = (st_q == ST_IDLE) && q_valid_i && slot_free;
  assign q_pop_o   = pop;
  assign safe_now  = !stop_q && wd_q && !tilt_q && !prox_q;

  always_comb begin
    ticks_d   = (ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;
    wd_tick   = wd_q && !(ticks_d > cfg_i.timeout);
    safe_tick = !stop_q && wd_tick && !tilt_q && !prox_q;
  end

  always_comb begin
    scan_b16 = q_entry_i.vals[1][15:0];
    scan_ok  = (mag32(q_entry_i.vals[0]) <= {18'd0, cfg_i.arc}) &&
               ($signed(q_entry_i.vals[1]) > $signed({16'd0, cfg_i.rmin})) &&
               ($signed(q_entry_i.vals[1]) < $signed({16'd0, cfg_i.rmax}));
    base     = open_q ? min_q : cfg_i.rmax;
    new_min  = (scan_ok && (scan_b16 < base)) ? scan_b16 : base;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      4'd0: begin
        mul_a = uy;
        mul_b = uy;
      end
      4'd1: begin
        mul_a = uz;
        mul_b = uz;
      end
      4'd2: begin
        mul_a = ux;
        mul_b = ux;
      end
      4'd3: begin
        mul_a = {16'd0, cfg_i.pitch};
        mul_b = {16'd0, cfg_i.pitch};
      end
      4'd4: begin
        mul_a = {16'd0, cfg_i.roll};
        mul_b = uz;
      end
      4'd5: begin
        mul_a = pp_q;
        mul_b = s_q[31:0];
      end
      4'd6: begin
        mul_a = pp_q;
        mul_b = s_q[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    if (az_q > 0) begin
      roll_f = {4'd0, uy, 12'd0} > rp_q;
    end else if (az_q < 0) begin
      roll_f = 1'b1;
    end else begin
      roll_f = (ay_q != 0);
    end
    if (s_q == '0) begin
      pitch_f = (ax_q != 0);
    end else begin
      pitch_f = {8'd0, sq_q, 24'd0} > rhs_q;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (pop && q_entry_i.op == msi_pkg::OP_ACCEL) begin
          st_d = ST_TILT;
        end else if (pop && q_entry_i.op == msi_pkg::OP_TICK && !safe_tick) begin
          st_d = ST_SECOND;
        end
      end
      ST_TILT: begin
        if (step_q == StepLast) begin
          st_d = ST_IDLE;
        end
      end
      ST_SECOND: begin
        if (slot_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (step_q)
      4'd1:    acc_q <= prod_q;
      4'd2:    s_q   <= acc_q + prod_q;
      4'd3:    sq_q  <= prod_q;
      4'd4:    pp_q  <= prod_q[31:0];
      4'd5:    rp_q  <= prod_q[47:0];
      4'd6:    lo_q  <= prod_q;
      4'd7:    rhs_q <= {prod_q, 32'd0} + {32'd0, lo_q};
      default: ;
    endcase
    if (pop && q_entry_i.op == msi_pkg::OP_ACCEL) begin
      ax_q <= q_entry_i.vals[0];
      ay_q <= q_entry_i.vals[1];
      az_q <= q_entry_i.vals[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_entry_i.op == msi_pkg::OP_VEL && safe_now) begin
      out_kind_q   <= msi_pkg::KIND_CMD;
      out_vals_q   <= q_entry_i.vals;
      out_status_q <= {prox_q, tilt_q, wd_q, stop_q, 1'b1};
      out_last_q   <= 1'b1;
    end else if (pop && q_entry_i.op == msi_pkg::OP_TICK) begin
      out_kind_q   <= safe_tick ? msi_pkg::KIND_STATUS : msi_pkg::KIND_CMD;
      out_vals_q   <= '0;
      out_status_q <= {prox_q, tilt_q, wd_tick, stop_q, safe_tick};
      out_last_q   <= safe_tick;
    end else if (st_q == ST_SECOND && slot_free) begin
      out_kind_q   <= msi_pkg::KIND_STATUS;
      out_vals_q   <= '0;
      out_status_q <= {prox_q, tilt_q, wd_q, stop_q, safe_now};
      out_last_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= '0;
      stop_q      <= 1'b0;
      wd_q        <= 1'b0;
      tilt_q      <= 1'b0;
      prox_q      <= 1'b0;
      open_q      <= 1'b0;
      ticks_q     <= '0;
      min_q       <= msi_pkg::RST_RMAX;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_TILT) begin
        step_q <= step_q + 4'd1;
        if (step_q == StepLast) begin
          tilt_q <= roll_f || pitch_f;
        end
      end else begin
        step_q <= '0;
      end
      if (pop) begin
        case (q_entry_i.op)
          msi_pkg::OP_STOP: begin
            stop_q  <= q_entry_i.stop_active;
            wd_q    <= 1'b1;
            ticks_q <= '0;
          end
          msi_pkg::OP_SCAN: begin
            if (q_entry_i.scan_last) begin
              prox_q <= new_min < cfg_i.prox;
              open_q <= 1'b0;
              min_q  <= cfg_i.rmax;
            end else begin
              open_q <= 1'b1;
              min_q  <= new_min;
            end
          end
          msi_pkg::OP_TICK: begin
            ticks_q <= ticks_d;
            wd_q    <= wd_tick;
          end
          default: ;
        endcase
      end
      if ((pop && q_entry_i.op == msi_pkg::OP_VEL && safe_now) ||
          (pop && q_entry_i.op == msi_pkg::OP_TICK) ||
          (st_q == ST_SECOND && slot_free)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_vals_o   = out_vals_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

`ifndef NO_ASSERTIONS
  a_second_holds_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_SECOND |-> out_valid_q)
    else $error("second result pending without first in output register");

  a_open_result_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> st_q == ST_SECOND)
    else $error("non-final result without pending status");

  a_cmd_final_is_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == msi_pkg::KIND_CMD && out_last_q |-> out_status_q[0])
    else $error("command passed while unsafe");

  a_no_pop_in_tilt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_TILT |-> !q_pop_o)
    else $error("queue popped during tilt check");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/motion_safety_interlock.sv
// ----------------------------------------------------------------------------
// motion_safety_interlock
// Throughput: one item per cycle while the back is idle and the output
// register is free; an accel sample holds the back for its tilt check (one
// shared 32x32 multiplier), an unsafe tick until its second result is loaded.
// Reset: asynchronous, clears fault state, queue and output register, and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_safety_interlock #(
  parameter int unsigned QueueDepth = msi_pkg::QueueDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // stop_active, value_a, value_b, value_c, value_d, value_e, value_f
  input  wire logic [199:0] s_axis_tdata,
  // cmd
  input  wire logic [2:0]   s_axis_tuser,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_linear_x, out_linear_y, out_linear_z, out_angular_x, out_angular_y,
  // out_angular_z, status_bits
  output logic [199:0]      m_axis_tdata,
  // kind
  output logic [0:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  msi_pkg::cfg_t   cfg_q;
  msi_pkg::entry_t push_entry, pop_entry;
  logic            q_full, q_push, q_valid, q_pop;
  logic            out_kind;
  logic [5:0][31:0] out_vals;
  logic [4:0]      out_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout <= msi_pkg::RST_TIMEOUT;
      cfg_q.roll    <= msi_pkg::RST_ROLL;
      cfg_q.pitch   <= msi_pkg::RST_PITCH;
      cfg_q.prox    <= msi_pkg::RST_PROX;
      cfg_q.arc     <= msi_pkg::RST_ARC;
      cfg_q.rmin    <= msi_pkg::RST_RMIN;
      cfg_q.rmax    <= msi_pkg::RST_RMAX;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        msi_pkg::CFG_TIMEOUT: cfg_q.timeout <= cfg_wdata_i;
        msi_pkg::CFG_ROLL:    cfg_q.roll    <= cfg_wdata_i;
        msi_pkg::CFG_PITCH:   cfg_q.pitch   <= cfg_wdata_i;
        msi_pkg::CFG_PROX:    cfg_q.prox    <= cfg_wdata_i;
        msi_pkg::CFG_ARC:     cfg_q.arc     <= cfg_wdata_i[13:0];
        msi_pkg::CFG_RMIN:    cfg_q.rmin    <= cfg_wdata_i;
        msi_pkg::CFG_RMAX:    cfg_q.rmax    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  msi_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  msi_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (pop_entry)
  );

  msi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (pop_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (out_kind),
    .out_vals_o   (out_vals),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, out_status, out_vals};
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire
